[rtl/core/prrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority round-robin scheduler package
// Queue entry layout, result status codes and the quantum reset value.
// ----------------------------------------------------------------------------
package prrs_pkg;

   // One ready-queue slot: id, priority and remaining run time
   typedef struct packed {
      logic [7:0]  id;
      logic [3:0]  prio;
      logic [15:0] run_time;
   } entry_type;

   // Result status codes
   localparam logic [2:0] STATUS_ADDED    = 3'd0;
   localparam logic [2:0] STATUS_FULL     = 3'd1;
   localparam logic [2:0] STATUS_REQUEUED = 3'd2;
   localparam logic [2:0] STATUS_FINISHED = 3'd3;
   localparam logic [2:0] STATUS_EMPTY    = 3'd4;

   // Input kind codes
   localparam logic KIND_ADD      = 1'b0;
   localparam logic KIND_DISPATCH = 1'b1;

   // Quantum after reset
   localparam logic [15:0] QUANTUM_RESET = 16'd80;

endpackage
`default_nettype wire

[rtl/core/prrs_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler channel interfaces
// Request, response and control-register channels with valid/ready beats.
// ----------------------------------------------------------------------------
interface prrs_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  task_id;
   logic [3:0]  task_priority;
   logic [15:0] run_time;

   modport source (output valid, kind, task_id, task_priority, run_time, input ready);
   modport sink   (input valid, kind, task_id, task_priority, run_time, output ready);
endinterface

interface prrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  ran_id;
   logic [3:0]  ran_priority;
   logic [15:0] time_left;

   modport source (output valid, status, ran_id, ran_priority, time_left, input ready);
   modport sink   (input valid, status, ran_id, ran_priority, time_left, output ready);
endinterface

interface prrs_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] time_quantum;

   modport source (output valid, time_quantum, input ready);
   modport sink   (input valid, time_quantum, output ready);
endinterface
`default_nettype wire

[rtl/core/prrs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module prrs_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/core/priority_round_robin_scheduler_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority round-robin scheduler
// Ready queue held as a circular buffer in RAM, ordered by descending
// priority; insertion walks back from the tail one slot at a time.
// ----------------------------------------------------------------------------
// Flow: an add walks back from the tail; a dispatch pops the head and either
//   finishes it or requeues it with a walk; a full-queue add or an empty
//   dispatch answers straight from idle.
// Requests: one item at a time, set by the read-compare-write walk over
//   the queue RAM (one read port).
// Reset: synchronous, empties the queue and sets the quantum to 80.
module priority_round_robin_scheduler_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   prrs_req_if.sink   req_bus,
   prrs_rsp_if.source rsp_bus,
   prrs_csr_if.sink   csr_bus
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = $bits(prrs_pkg::entry_type);

   typedef enum logic [3:0] {
      S_IDLE     = 4'b0001,
      S_POP      = 4'b0010,
      S_WALK_RD  = 4'b0100,
      S_WALK_CMP = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   prrs_pkg::entry_type task_ff, task_in;
   logic [15:0]         quantum_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          status_ff, status_in;
   logic [7:0]          ran_id_ff, ran_id_in;
   logic [3:0]          ran_prio_ff, ran_prio_in;
   logic [15:0]         left_ff, left_in;

   logic                req_beat;
   logic [CW-1:0]       log_idx;
   logic [AW:0]         phys_sum;
   logic [AW-1:0]       phys_addr;
   logic [AW-1:0]       head_next;
   logic [16:0]         diff;
   logic                finished;
   prrs_pkg::entry_type rd_entry;
   logic [EW-1:0]       rd_word;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   prrs_pkg::entry_type wr_entry;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;

   // Handshakes
   assign req_bus.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.ran_id       = ran_id_ff;
   assign rsp_bus.ran_priority = ran_prio_ff;
   assign rsp_bus.time_left    = left_ff;

   // Shared circular address unit: logical position to RAM slot
   assign log_idx   = (state_ff == S_WALK_RD) ? idx_ff - CW'(1) : idx_ff;
   assign phys_sum  = {1'b0, head_ff} + (AW+1)'(log_idx);
   assign phys_addr = (phys_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                      AW'(phys_sum - (AW+1)'(QUEUE_DEPTH)) : phys_sum[AW-1:0];
   assign head_next = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);

   // Charge one quantum to the popped head
   assign rd_entry = prrs_pkg::entry_type'(rd_word);
   assign diff     = {1'b0, rd_entry.run_time} - {1'b0, quantum_ff};
   assign finished = diff[16] || (diff[15:0] == 16'd0);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      task_in      = task_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      ran_id_in    = ran_id_ff;
      ran_prio_in  = ran_prio_ff;
      left_in      = left_ff;
      wr_en        = 1'b0;
      wr_addr      = phys_addr;
      wr_entry     = task_ff;
      rd_en        = 1'b0;
      rd_addr      = phys_addr;

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               ran_id_in   = '0;
               ran_prio_in = '0;
               left_in     = '0;
               if (req_bus.kind == prrs_pkg::KIND_ADD) begin
                  if (count_ff == CW'(QUEUE_DEPTH)) begin
                     status_in    = prrs_pkg::STATUS_FULL;
                     rsp_valid_in = 1'b1;
                  end else begin
                     status_in        = prrs_pkg::STATUS_ADDED;
                     task_in.id       = req_bus.task_id;
                     task_in.prio     = req_bus.task_priority;
                     task_in.run_time = req_bus.run_time;
                     idx_in           = count_ff;
                     count_in         = count_ff + CW'(1);
                     state_in         = S_WALK_RD;
                  end
               end else if (count_ff == '0) begin
                  status_in    = prrs_pkg::STATUS_EMPTY;
                  rsp_valid_in = 1'b1;
               end else begin
                  // fetch the head slot
                  rd_en    = 1'b1;
                  rd_addr  = head_ff;
                  state_in = S_POP;
               end
            end
         end

         S_POP: begin
            head_in     = head_next;
            ran_id_in   = rd_entry.id;
            ran_prio_in = rd_entry.prio;
            if (finished) begin
               count_in     = count_ff - CW'(1);
               status_in    = prrs_pkg::STATUS_FINISHED;
               left_in      = '0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               // requeue behind equal-priority peers; count is unchanged
               status_in        = prrs_pkg::STATUS_REQUEUED;
               left_in          = diff[15:0];
               task_in.id       = rd_entry.id;
               task_in.prio     = rd_entry.prio;
               task_in.run_time = diff[15:0];
               idx_in           = count_ff - CW'(1);
               state_in         = S_WALK_RD;
            end
         end

         S_WALK_RD: begin
            if (idx_ff == '0) begin
               wr_en        = 1'b1;
               wr_addr      = head_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_WALK_CMP;
            end
         end

         S_WALK_CMP: begin
            wr_en = 1'b1;
            if (rd_entry.prio < task_ff.prio) begin
               // move the lower-priority entry one slot back
               wr_entry = rd_entry;
               idx_in   = idx_ff - CW'(1);
               state_in = S_WALK_RD;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         quantum_ff   <= prrs_pkg::QUANTUM_RESET;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            quantum_ff <= csr_bus.time_quantum;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      task_ff     <= task_in;
      status_ff   <= status_in;
      ran_id_ff   <= ran_id_in;
      ran_prio_ff <= ran_prio_in;
      left_ff     <= left_in;
   end

   // Ready-queue storage
   prrs_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

endmodule
`default_nettype wire

[rtl/core/prrs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the top-level ports over time and reports protocol or result slips.
// ----------------------------------------------------------------------------
module prrs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [7:0]  rsp_ran_id,
   input wire logic [15:0] rsp_time_left
);

   // No result beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // One item at a time: busy after a request beat
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");

   // No new request while a result waits
   a_no_req_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while result pending");

   // Field consistency of results
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= prrs_pkg::STATUS_EMPTY) &&
         ((rsp_status != prrs_pkg::STATUS_FINISHED) || (rsp_time_left == 16'd0)) &&
         ((rsp_status != prrs_pkg::STATUS_ADDED) ||
          ((rsp_ran_id == 8'd0) && (rsp_time_left == 16'd0))))
      else $error("inconsistent result fields");

endmodule

bind priority_round_robin_scheduler_unit prrs_checker u_prrs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_status    (rsp_bus.status),
   .rsp_ran_id    (rsp_bus.ran_id),
   .rsp_time_left (rsp_bus.time_left)
);
`default_nettype wire
